/* rtl/pns_pkg.sv */
// ----------------------------------------------------------------------------
// pns_pkg
// Shared types, fixed-point formats, filter coefficients and command codes
// for the pink noise shaper.
// ----------------------------------------------------------------------------
package pns_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int MOD_W       = 16;
    localparam int AMP_W       = 16;
    localparam int STATE_W     = 32;
    localparam int COEF_W      = 32;
    localparam int GAIN_W      = 2 * AMP_W;
    localparam int MAG_W       = 32;
    localparam int PROD_W      = 2 * MAG_W;
    localparam int RES_W       = 34;
    localparam int SUM_W       = 36;
    localparam int NUM_POLES   = 6;
    localparam int NUM_TAPS    = NUM_POLES + 1;
    localparam int TAP_IDX_W   = 3;
    localparam int REG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    // binary points
    localparam int CQ          = 30;
    localparam int SAMPLE_FRAC = SAMPLE_W - 1;
    localparam int STATE_FRAC  = STATE_W - 7;

    localparam int SHIFT_WS_AMT   = CQ + SAMPLE_FRAC - STATE_FRAC;
    localparam int SHIFT_COEF_AMT = CQ;
    localparam int SHIFT_PINK_AMT = STATE_FRAC + CQ - SAMPLE_FRAC;

    localparam logic [TAP_IDX_W-1:0] TAP_DELAY = TAP_IDX_W'(NUM_POLES);

    localparam logic [REG_IDX_W-1:0] REG_NOISE_MODE = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_AMPLITUDE  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_MOD_ENABLE = 2'd2;

    localparam logic [AMP_W-1:0] AMPLITUDE_RESET = 16'd16384;
    localparam logic [AMP_W-1:0] UNITY_FACTOR    = 16'h8000;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [MOD_W-1:0]    mod_t;
    typedef logic signed [STATE_W-1:0]  state_t;
    typedef logic signed [COEF_W-1:0]   coef_t;
    typedef logic signed [RES_W-1:0]    res_t;
    typedef logic signed [SUM_W-1:0]    sum_t;
    typedef logic [MAG_W-1:0]           mag_t;
    typedef logic [GAIN_W-1:0]          gain_t;

    localparam coef_t K_FIFTH  = 32'sd214748365;
    localparam coef_t K_DIRECT = 32'sd575740366;
    localparam coef_t K_DELAY  = 32'sd124474595;

    typedef enum logic [2:0] {
        OP_FIFTH     = 3'd0,
        OP_POLE      = 3'd1,
        OP_FEED      = 3'd2,
        OP_DIRECT    = 3'd3,
        OP_DELAY     = 3'd4,
        OP_OUT_PINK  = 3'd5,
        OP_OUT_WHITE = 3'd6
    } op_t;

    typedef enum logic [1:0] {
        SHIFT_WS   = 2'd0,
        SHIFT_COEF = 2'd1,
        SHIFT_PINK = 2'd2
    } shift_t;

    typedef struct packed {
        op_t                  op;
        logic [TAP_IDX_W-1:0] idx;
    } tag_t;

    typedef struct packed {
        logic                 load;
        logic                 issue;
        op_t                  op;
        logic [TAP_IDX_W-1:0] idx;
    } cmd_t;

    typedef struct packed {
        logic pipe_busy;
        logic out_full;
    } status_t;

    function automatic coef_t pole_coef(logic [TAP_IDX_W-1:0] idx);
        case (idx)
            3'd0:    pole_coef = 32'sd1072517758;
            3'd1:    pole_coef = 32'sd1066569229;
            3'd2:    pole_coef = 32'sd1040455827;
            3'd3:    pole_coef = 32'sd930397290;
            3'd4:    pole_coef = 32'sd590558003;
            3'd5:    pole_coef = -32'sd817761773;
            default: pole_coef = '0;
        endcase
    endfunction

    function automatic coef_t feed_coef(logic [TAP_IDX_W-1:0] idx);
        case (idx)
            3'd0:    feed_coef = 32'sd59611891;
            3'd1:    feed_coef = 32'sd80612134;
            3'd2:    feed_coef = 32'sd165197327;
            3'd3:    feed_coef = 32'sd333381374;
            3'd4:    feed_coef = 32'sd572253067;
            3'd5:    feed_coef = -32'sd18144089;
            default: feed_coef = '0;
        endcase
    endfunction

    function automatic mag_t coef_mag(coef_t c);
        coef_mag = c[COEF_W-1] ? mag_t'(-c) : mag_t'(c);
    endfunction

    function automatic mag_t state_mag(state_t x);
        logic signed [STATE_W:0] e;
        e = (STATE_W+1)'(x);
        if (x[STATE_W-1])
        begin
            e = -e;
        end
        state_mag = e[MAG_W-1:0];
    endfunction

    function automatic state_t sat_state(sum_t x);
        logic ovf;
        ovf = (x[SUM_W-1:STATE_W-1] != {(SUM_W-STATE_W+1){x[SUM_W-1]}});
        if (!ovf)
        begin
            sat_state = x[STATE_W-1:0];
        end
        else
        begin
            sat_state = x[SUM_W-1] ? {1'b1, {(STATE_W-1){1'b0}}}
                                   : {1'b0, {(STATE_W-1){1'b1}}};
        end
    endfunction

    function automatic logic sample_ovf(res_t x);
        sample_ovf = (x[RES_W-1:SAMPLE_W-1] != {(RES_W-SAMPLE_W+1){x[RES_W-1]}});
    endfunction

    function automatic sample_t sat_sample(res_t x);
        if (!sample_ovf(x))
        begin
            sat_sample = x[SAMPLE_W-1:0];
        end
        else
        begin
            sat_sample = x[RES_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}}
                                    : {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
    endfunction

endpackage

/* rtl/pns_if.sv */
// ----------------------------------------------------------------------------
// pns_if
// Valid/ready request channels for the noise shaper input and output.
// ----------------------------------------------------------------------------
interface pns_in_if;
    logic             valid;
    logic             ready;
    pns_pkg::sample_t white_sample;
    pns_pkg::mod_t    amp_mod;

    modport source (output valid, output white_sample, output amp_mod, input ready);
    modport sink   (input valid, input white_sample, input amp_mod, output ready);
endinterface

interface pns_out_if;
    logic             valid;
    logic             ready;
    pns_pkg::sample_t noise_sample;
    logic             clipped;

    modport source (output valid, output noise_sample, output clipped, input ready);
    modport sink   (input valid, input noise_sample, input clipped, output ready);
endinterface

/* rtl/pns_mul.sv */
// ----------------------------------------------------------------------------
// pns_mul
// Shared sign-magnitude multiplier: 32x32 product, then round half away
// from zero and shift, two register stages.
// ----------------------------------------------------------------------------
module pns_mul (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             issue,
    input  pns_pkg::mag_t    a_mag,
    input  pns_pkg::mag_t    b_mag,
    input  logic             neg,
    input  pns_pkg::shift_t  shift,
    input  pns_pkg::tag_t    tag_in,
    output logic             res_valid,
    output pns_pkg::res_t    res,
    output pns_pkg::tag_t    res_tag,
    output logic             busy
);

    logic                        a_valid_reg;
    logic [pns_pkg::PROD_W-1:0]  prod_reg;
    logic                        a_neg_reg;
    pns_pkg::shift_t             a_shift_reg;
    pns_pkg::tag_t               a_tag_reg;

    logic                        b_valid_reg;
    pns_pkg::res_t               res_reg;
    pns_pkg::tag_t               b_tag_reg;

    logic [pns_pkg::PROD_W:0]    half;
    logic [pns_pkg::PROD_W:0]    rsum;
    logic [pns_pkg::PROD_W:0]    q;
    logic signed [pns_pkg::RES_W-1:0] mag_ext;
    pns_pkg::res_t               res_next;

    always_comb
    begin
        case (a_shift_reg)
            pns_pkg::SHIFT_WS:   half = (pns_pkg::PROD_W+1)'(1) << (pns_pkg::SHIFT_WS_AMT - 1);
            pns_pkg::SHIFT_COEF: half = (pns_pkg::PROD_W+1)'(1) << (pns_pkg::SHIFT_COEF_AMT - 1);
            pns_pkg::SHIFT_PINK: half = (pns_pkg::PROD_W+1)'(1) << (pns_pkg::SHIFT_PINK_AMT - 1);
            default:             half = '0;
        endcase
        rsum = {1'b0, prod_reg} + half;
        case (a_shift_reg)
            pns_pkg::SHIFT_WS:   q = rsum >> pns_pkg::SHIFT_WS_AMT;
            pns_pkg::SHIFT_COEF: q = rsum >> pns_pkg::SHIFT_COEF_AMT;
            pns_pkg::SHIFT_PINK: q = rsum >> pns_pkg::SHIFT_PINK_AMT;
            default:             q = '0;
        endcase
        // rounded magnitude stays below 2^33 for every operation
        mag_ext  = {1'b0, q[pns_pkg::RES_W-2:0]};
        res_next = a_neg_reg ? -mag_ext : mag_ext;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= issue;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg    <= a_mag * b_mag;
        a_neg_reg   <= neg;
        a_shift_reg <= shift;
        a_tag_reg   <= tag_in;
        res_reg     <= res_next;
        b_tag_reg   <= a_tag_reg;
    end

    assign res_valid = b_valid_reg;
    assign res       = res_reg;
    assign res_tag   = b_tag_reg;
    assign busy      = a_valid_reg | b_valid_reg;

endmodule

/* rtl/pns_dp.sv */
// ----------------------------------------------------------------------------
// pns_dp
// Datapath: filter taps, gain, operand selection for the shared multiplier,
// result writeback and the output register.
// ----------------------------------------------------------------------------
module pns_dp (
    input  logic                       clk,
    input  logic                       rst_n,
    input  pns_pkg::cmd_t              cmd,
    output pns_pkg::status_t           status,
    input  logic [pns_pkg::AMP_W-1:0]  amplitude,
    input  logic                       mod_enable,
    input  pns_pkg::sample_t           white_sample,
    input  pns_pkg::mod_t              amp_mod,
    output logic                       out_valid,
    input  logic                       out_ready,
    output pns_pkg::sample_t           noise_sample,
    output logic                       clipped
);

    pns_pkg::state_t  tap_reg [pns_pkg::NUM_TAPS];
    pns_pkg::res_t    part_reg [pns_pkg::NUM_POLES];
    pns_pkg::state_t  ws_reg;
    pns_pkg::sum_t    sum_reg;
    pns_pkg::sample_t w_reg;
    pns_pkg::gain_t   gain_reg;
    pns_pkg::sample_t noise_reg;
    logic             clipped_reg;
    logic             out_full_reg;

    logic [pns_pkg::AMP_W-1:0] factor;
    pns_pkg::mag_t    a_mag;
    pns_pkg::mag_t    b_mag;
    logic             neg;
    pns_pkg::shift_t  shift;
    pns_pkg::coef_t   coef;
    pns_pkg::state_t  tap_sel;
    pns_pkg::state_t  w_ext;
    pns_pkg::state_t  sig;
    pns_pkg::tag_t    tag_in;

    logic             res_valid;
    pns_pkg::res_t    res;
    pns_pkg::tag_t    res_tag;
    logic             mul_busy;

    pns_pkg::state_t  new_tap;
    logic             out_wb;

    // 1 + modulation in Q1.15 is the offset-binary form of amp_mod
    assign factor = mod_enable ? {~amp_mod[pns_pkg::MOD_W-1], amp_mod[pns_pkg::MOD_W-2:0]}
                               : pns_pkg::UNITY_FACTOR;

    assign w_ext   = pns_pkg::STATE_W'(w_reg);
    assign sig     = pns_pkg::sat_state(sum_reg);
    assign tap_sel = tap_reg[cmd.idx];
    assign tag_in  = '{op: cmd.op, idx: cmd.idx};

    always_comb
    begin
        a_mag = '0;
        b_mag = '0;
        neg   = 1'b0;
        shift = pns_pkg::SHIFT_COEF;
        coef  = '0;
        case (cmd.op)
            pns_pkg::OP_FIFTH:
            begin
                a_mag = pns_pkg::state_mag(w_ext);
                b_mag = pns_pkg::coef_mag(pns_pkg::K_FIFTH);
                neg   = w_reg[pns_pkg::SAMPLE_W-1];
                shift = pns_pkg::SHIFT_WS;
            end
            pns_pkg::OP_POLE:
            begin
                coef  = pns_pkg::pole_coef(cmd.idx);
                a_mag = pns_pkg::state_mag(tap_sel);
                b_mag = pns_pkg::coef_mag(coef);
                neg   = tap_sel[pns_pkg::STATE_W-1] ^ coef[pns_pkg::COEF_W-1];
            end
            pns_pkg::OP_FEED:
            begin
                coef  = pns_pkg::feed_coef(cmd.idx);
                a_mag = pns_pkg::state_mag(ws_reg);
                b_mag = pns_pkg::coef_mag(coef);
                neg   = ws_reg[pns_pkg::STATE_W-1] ^ coef[pns_pkg::COEF_W-1];
            end
            pns_pkg::OP_DIRECT:
            begin
                a_mag = pns_pkg::state_mag(ws_reg);
                b_mag = pns_pkg::coef_mag(pns_pkg::K_DIRECT);
                neg   = ws_reg[pns_pkg::STATE_W-1];
            end
            pns_pkg::OP_DELAY:
            begin
                a_mag = pns_pkg::state_mag(ws_reg);
                b_mag = pns_pkg::coef_mag(pns_pkg::K_DELAY);
                neg   = ws_reg[pns_pkg::STATE_W-1];
            end
            pns_pkg::OP_OUT_PINK:
            begin
                a_mag = pns_pkg::state_mag(sig);
                b_mag = pns_pkg::MAG_W'(gain_reg);
                neg   = sig[pns_pkg::STATE_W-1];
                shift = pns_pkg::SHIFT_PINK;
            end
            pns_pkg::OP_OUT_WHITE:
            begin
                a_mag = pns_pkg::state_mag(w_ext);
                b_mag = pns_pkg::MAG_W'(gain_reg);
                neg   = w_reg[pns_pkg::SAMPLE_W-1];
            end
            default:
            begin
                a_mag = '0;
            end
        endcase
    end

    pns_mul u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .issue     (cmd.issue),
        .a_mag     (a_mag),
        .b_mag     (b_mag),
        .neg       (neg),
        .shift     (shift),
        .tag_in    (tag_in),
        .res_valid (res_valid),
        .res       (res),
        .res_tag   (res_tag),
        .busy      (mul_busy)
    );

    assign new_tap = pns_pkg::sat_state(pns_pkg::SUM_W'(part_reg[res_tag.idx])
                                        + pns_pkg::SUM_W'(res));
    assign out_wb  = res_valid && (res_tag.op == pns_pkg::OP_OUT_PINK ||
                                   res_tag.op == pns_pkg::OP_OUT_WHITE);

    // filter state and output handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < pns_pkg::NUM_TAPS; i++)
            begin
                tap_reg[i] <= '0;
            end
            out_full_reg <= 1'b0;
        end
        else
        begin
            if (res_valid && res_tag.op == pns_pkg::OP_FEED)
            begin
                tap_reg[res_tag.idx] <= new_tap;
            end
            if (res_valid && res_tag.op == pns_pkg::OP_DELAY)
            begin
                tap_reg[pns_pkg::TAP_DELAY] <= pns_pkg::sat_state(pns_pkg::SUM_W'(res));
            end
            if (out_wb)
            begin
                out_full_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_full_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            w_reg    <= white_sample;
            gain_reg <= pns_pkg::GAIN_W'(amplitude) * pns_pkg::GAIN_W'(factor);
            sum_reg  <= pns_pkg::SUM_W'(tap_reg[pns_pkg::TAP_DELAY]);
        end
        else if (res_valid && res_tag.op == pns_pkg::OP_FEED)
        begin
            sum_reg <= sum_reg + pns_pkg::SUM_W'(new_tap);
        end
        else if (res_valid && res_tag.op == pns_pkg::OP_DIRECT)
        begin
            sum_reg <= sum_reg + pns_pkg::SUM_W'(res);
        end
        if (res_valid && res_tag.op == pns_pkg::OP_FIFTH)
        begin
            ws_reg <= res[pns_pkg::STATE_W-1:0];
        end
        if (res_valid && res_tag.op == pns_pkg::OP_POLE)
        begin
            part_reg[res_tag.idx] <= res;
        end
        if (out_wb)
        begin
            noise_reg   <= pns_pkg::sat_sample(res);
            clipped_reg <= pns_pkg::sample_ovf(res);
        end
    end

    assign status.pipe_busy = mul_busy;
    assign status.out_full  = out_full_reg;
    assign out_valid        = out_full_reg;
    assign noise_sample     = noise_reg;
    assign clipped          = clipped_reg;

    a_out_wb_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_wb |-> !out_full_reg)
        else $error("output writeback over an unread result");

    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> !mul_busy && !cmd.issue)
        else $error("new request loaded while multiplier busy");

    a_out_issue: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue && (cmd.op == pns_pkg::OP_OUT_PINK || cmd.op == pns_pkg::OP_OUT_WHITE)
        |-> !mul_busy && !out_full_reg)
        else $error("output product issued before sum settled or output free");

    a_feed_ws: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue && cmd.op == pns_pkg::OP_FEED
        |-> !(res_valid && res_tag.op == pns_pkg::OP_FIFTH))
        else $error("feed product issued before scaled input written");

endmodule

/* rtl/pns_ctrl.sv */
// ----------------------------------------------------------------------------
// pns_ctrl
// Controller: accepts a request, steps the datapath through the filter
// products in pink mode only, and issues the final gain product.
// ----------------------------------------------------------------------------
module pns_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              noise_mode,
    input  logic              in_valid,
    output logic              in_ready,
    input  pns_pkg::status_t  status,
    output pns_pkg::cmd_t     cmd
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_FILTER = 4'b0010,
        ST_SETTLE = 4'b0100,
        ST_DRAIN  = 4'b1000
    } state_t;

    localparam logic [3:0] STEP_FIFTH  = 4'd0;
    localparam logic [3:0] STEP_POLE   = 4'd1;
    localparam logic [3:0] STEP_FEED   = 4'd7;
    localparam logic [3:0] STEP_DIRECT = 4'd13;
    localparam logic [3:0] STEP_DELAY  = 4'd14;

    state_t     state_reg;
    state_t     state_next;
    logic [3:0] step_reg;
    logic [3:0] step_next;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        in_ready   = 1'b0;
        cmd        = '{load: 1'b0, issue: 1'b0, op: pns_pkg::OP_FIFTH, idx: '0};
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    step_next  = STEP_FIFTH;
                    state_next = noise_mode ? ST_FILTER : ST_SETTLE;
                end
            end
            ST_FILTER:
            begin
                cmd.issue = 1'b1;
                case (step_reg) inside
                    STEP_FIFTH:
                    begin
                        cmd.op = pns_pkg::OP_FIFTH;
                    end
                    [4'd1:4'd6]:
                    begin
                        cmd.op  = pns_pkg::OP_POLE;
                        cmd.idx = pns_pkg::TAP_IDX_W'(step_reg - STEP_POLE);
                    end
                    [4'd7:4'd12]:
                    begin
                        cmd.op  = pns_pkg::OP_FEED;
                        cmd.idx = pns_pkg::TAP_IDX_W'(step_reg - STEP_FEED);
                    end
                    STEP_DIRECT:
                    begin
                        cmd.op = pns_pkg::OP_DIRECT;
                    end
                    default:
                    begin
                        cmd.op = pns_pkg::OP_DELAY;
                    end
                endcase
                if (step_reg == STEP_DELAY)
                begin
                    state_next = ST_SETTLE;
                end
                else
                begin
                    step_next = step_reg + 4'd1;
                end
            end
            ST_SETTLE:
            begin
                // sum must be complete and the output register free
                if (!status.pipe_busy && !status.out_full)
                begin
                    cmd.issue  = 1'b1;
                    cmd.op     = noise_mode ? pns_pkg::OP_OUT_PINK : pns_pkg::OP_OUT_WHITE;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= STEP_FIFTH;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

/* rtl/pink_noise_shaper.sv */
// ----------------------------------------------------------------------------
// pink_noise_shaper
// Pink or white noise with amplitude and modulation gain, saturated Q1.15.
// Requests are handled one at a time: a new request is accepted only after
// the previous result is written to the output register. White mode skips
// the filter products. All products share the single 32x32 multiplier and
// its two pipeline stages. Reset clears the seven filter taps at once and
// loads the register defaults; no clearing pass.
// ----------------------------------------------------------------------------
module pink_noise_shaper (
    input  logic                              clk,
    input  logic                              rst_n,
    pns_in_if.sink                            sample_in,
    pns_out_if.source                         sample_out,
    input  logic                              write_enable,
    input  logic [pns_pkg::REG_IDX_W-1:0]     reg_index,
    input  logic [pns_pkg::CFG_DATA_W-1:0]    write_data
);

    logic                        noise_mode_reg;
    logic [pns_pkg::AMP_W-1:0]   amplitude_reg;
    logic                        mod_enable_reg;

    pns_pkg::cmd_t               cmd;
    pns_pkg::status_t            status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            noise_mode_reg <= 1'b1;
            amplitude_reg  <= pns_pkg::AMPLITUDE_RESET;
            mod_enable_reg <= 1'b0;
        end
        else if (write_enable)
        begin
            unique case (reg_index)
                pns_pkg::REG_NOISE_MODE: noise_mode_reg <= write_data[0];
                pns_pkg::REG_AMPLITUDE:  amplitude_reg  <= write_data[pns_pkg::AMP_W-1:0];
                pns_pkg::REG_MOD_ENABLE: mod_enable_reg <= write_data[0];
                default:
                begin
                    // unknown index: ignored
                end
            endcase
        end
    end

    pns_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .noise_mode (noise_mode_reg),
        .in_valid   (sample_in.valid),
        .in_ready   (sample_in.ready),
        .status     (status),
        .cmd        (cmd)
    );

    pns_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .amplitude    (amplitude_reg),
        .mod_enable   (mod_enable_reg),
        .white_sample (sample_in.white_sample),
        .amp_mod      (sample_in.amp_mod),
        .out_valid    (sample_out.valid),
        .out_ready    (sample_out.ready),
        .noise_sample (sample_out.noise_sample),
        .clipped      (sample_out.clipped)
    );

endmodule
